FILE: hdl/assert_macros.svh
// Assertion macros shared by the object store RTL.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: hdl/tplos_pkg.sv
// Package for the two-page log object store: sizes, status codes, entry layout.
// Depends on nothing.
package tplos_pkg;
    localparam int ENTRY_SLOTS = 1024;
    localparam int DATA_BYTES  = 16384;
    localparam int EW = $clog2(ENTRY_SLOTS);
    localparam int DW = $clog2(DATA_BYTES);
    localparam int EFW = $clog2(ENTRY_SLOTS + 1);
    localparam int DFW = $clog2(DATA_BYTES + 256);
    localparam logic [7:0] BAD_ID = 8'hFF;

    // Request kinds on the mode input
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_BAD_ID  = 2'd1;
    localparam status_t ST_MISSING = 2'd2;
    localparam status_t ST_FULL    = 2'd3;

    typedef struct packed {
        logic [7:0]    id;
        logic [7:0]    len;
        logic [DW-1:0] off;
    } rec_t;
endpackage

FILE: hdl/two_page_log_object_store_top.sv
// Two-page log object store: top level with sequencer, logs and compaction.
// Depends on tplos_pkg and assert_macros.svh.
//
// Usage: present an item on mode/obj_key/total_length/max_length/write_data/
// last_chunk and raise start while busy is low; the item transfers at that edge.
// Results come out on status/stored_length/read_data/byte_count/last, each
// valid for the single cycle that out_valid is high; the receiver cannot stall.
// An invalid id on a read or a first write chunk answers in the cycle after
// the transfer. A write chunk stores its bytes in S_WBYTE, at most one data RAM
// write a cycle, then answers; a first chunk passes the room check in S_ROOM,
// a last chunk zero-fills the rest of the object and commits in S_WCOMMIT.
// A first chunk that overflows the page triggers compaction: for each of the
// 255 ids a backward scan of the source entry log (S_CSCAN, S_CSCANCHK per
// entry) and a copy of its newest entry's bytes to the other page (S_CBYTE,
// S_CBYTEWR per byte). A read scans the entry log backward (S_SCAN, S_SCANCHK
// per entry), fetches bytes (S_RBYTE, S_RBYTECHK per byte) and emits each
// result. busy stays high through the last result; the next item can transfer
// in the cycle after it. Reset clears the active page, both fill counts and any
// pending write; the log memories are not cleared.
module two_page_log_object_store_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [7:0]  obj_key,
    input  logic [7:0]  total_length,
    input  logic [7:0]  max_length,
    input  logic [63:0] write_data,
    input  logic        last_chunk,
    output logic        out_valid,
    output tplos_pkg::status_t status,
    output logic [7:0]  stored_length,
    output logic [63:0] read_data,
    output logic [3:0]  byte_count,
    output logic        last
);
    import tplos_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_WBYTE, S_WCOMMIT, S_SCAN, S_SCANCHK, S_RBYTE, S_RBYTECHK, S_ROOM,
        S_CSCAN, S_CSCANCHK, S_CBYTE, S_CBYTEWR, S_CNEXT, S_EMIT
    } state_t;

    // Memories, page bit in the top address bit
    rec_t       entry_mem [2*ENTRY_SLOTS];
    logic [7:0] data_mem  [2*DATA_BYTES];
    rec_t       erd_reg;
    logic [7:0] drd_reg;

    state_t state_reg;
    logic   page_reg;
    logic [EFW-1:0] efill_reg [2];
    logic [DFW-1:0] dfill_reg [2];
    logic        pw_act_reg;
    logic [7:0]  pw_id_reg, pw_len_reg, pw_got_reg;
    // Latched item
    logic        mode_reg, lc_reg;
    logic [7:0]  id_reg, mlen_reg;
    logic [63:0] wd_reg;
    // Working registers
    logic [EFW-1:0] n_reg;
    logic [3:0]     i_reg;
    logic [7:0]     cid_reg, cnt_reg, ln_reg, done_reg;
    rec_t           rec_reg;
    logic           compacted_reg;
    logic           last_reg;
    status_t        st_reg;
    logic [7:0]     sl_reg;
    logic [63:0]    rd_reg;
    logic [3:0]     bc_reg;

    // Memory port control
    logic                  ewe, dwe;
    logic [EW:0]           eaddr;
    logic [DW:0]           daddr, dwaddr;
    rec_t                  ewdata;
    logic [7:0]            dwdata;

    always_ff @(posedge clk)
    begin
        if (ewe)
            entry_mem[eaddr] <= ewdata;
        erd_reg <= entry_mem[eaddr];
        if (dwe)
            data_mem[dwaddr] <= dwdata;
        drd_reg <= data_mem[daddr];
    end

    logic src, dst;
    logic [DFW-1:0] wa;
    logic [DFW:0]   room_d;
    logic           room;
    logic [7:0]     nb;
    logic [8:0]     done_p1;
    logic [EFW-1:0] n_dec;
    assign src = page_reg;
    assign dst = ~page_reg;
    assign wa  = dfill_reg[page_reg] + DFW'(pw_got_reg);
    assign room_d = {1'b0, dfill_reg[page_reg]} + (DFW+1)'(ln_reg);
    assign room = (efill_reg[page_reg] + EFW'(1) <= EFW'(ENTRY_SLOTS - 2)) &&
                  (room_d <= (DFW+1)'(DATA_BYTES - 1));
    assign nb = (erd_reg.len > mlen_reg) ? mlen_reg : erd_reg.len;
    assign done_p1 = {1'b0, done_reg} + 9'd1;
    assign n_dec = n_reg - EFW'(1);

    // Memory addressing per state
    always_comb
    begin
        ewe = 1'b0; dwe = 1'b0;
        eaddr = {page_reg, n_reg[EW-1:0]};
        daddr = {page_reg, rec_reg.off + DW'(done_reg)};
        dwaddr = {page_reg, wa[DW-1:0]};
        ewdata = rec_reg; dwdata = 8'h00;
        case (state_reg)
            S_WBYTE:
            begin
                dwe = (pw_got_reg < pw_len_reg) && (wa < DFW'(DATA_BYTES)) &&
                      (!i_reg[3] || lc_reg);
                dwdata = (i_reg[3]) ? 8'h00 : wd_reg[8*i_reg[2:0] +: 8];
            end
            S_WCOMMIT:
            begin
                ewe = efill_reg[page_reg] < EFW'(ENTRY_SLOTS);
                eaddr = {page_reg, efill_reg[page_reg][EW-1:0]};
                ewdata = '{id: pw_id_reg, len: pw_len_reg,
                           off: dfill_reg[page_reg][DW-1:0]};
            end
            S_SCAN: eaddr = {page_reg, n_dec[EW-1:0]};
            S_CSCAN: eaddr = {src, n_dec[EW-1:0]};
            S_CBYTE: daddr = {src, rec_reg.off + DW'(done_reg)};
            S_CBYTEWR:
            begin
                dwaddr = {dst, dfill_reg[dst][DW-1:0] + DW'(done_reg)};
                dwe = (DFW'(rec_reg.off) + DFW'(done_reg) < DFW'(DATA_BYTES)) &&
                      (dfill_reg[dst] + DFW'(done_reg) < DFW'(DATA_BYTES));
                dwdata = drd_reg;
            end
            S_CNEXT:
            begin
                eaddr = {dst, efill_reg[dst][EW-1:0]};
                ewe = (rec_reg.id != BAD_ID) && (efill_reg[dst] < EFW'(ENTRY_SLOTS));
                ewdata = '{id: rec_reg.id, len: rec_reg.len,
                           off: dfill_reg[dst][DW-1:0]};
            end
            default: ;
        endcase
    end

    // Sequencer: state, page bookkeeping and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            page_reg <= 1'b0;
            efill_reg[0] <= '0; efill_reg[1] <= '0;
            dfill_reg[0] <= '0; dfill_reg[1] <= '0;
            pw_act_reg <= 1'b0;
            st_reg <= ST_OK;
            sl_reg <= '0;
            rd_reg <= '0;
            bc_reg <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (start)
                    begin
                        mode_reg <= mode; id_reg <= obj_key; mlen_reg <= max_length;
                        wd_reg <= write_data; lc_reg <= last_chunk;
                        ln_reg <= total_length;
                        compacted_reg <= 1'b0; i_reg <= '0; done_reg <= '0;
                        sl_reg <= '0; rd_reg <= '0; bc_reg <= '0;
                        n_reg <= efill_reg[page_reg];
                        st_reg <= (obj_key == BAD_ID) ? ST_BAD_ID : ST_OK;
                        last_reg <= 1'b1;
                        // first chunk of a write with a valid id goes to the room check
                        if (mode == MODE_READ)
                            state_reg <= (obj_key == BAD_ID) ? S_EMIT : S_SCAN;
                        else if (pw_act_reg)
                            state_reg <= S_WBYTE;
                        else
                            state_reg <= (obj_key == BAD_ID) ? S_EMIT : S_ROOM;
                    end
                S_WBYTE:
                begin
                    if (pw_got_reg < pw_len_reg && (!i_reg[3] || lc_reg))
                        pw_got_reg <= pw_got_reg + 8'd1;
                    if (i_reg[3] && (!lc_reg || pw_got_reg >= pw_len_reg))
                    begin
                        last_reg <= lc_reg; st_reg <= ST_OK;
                        state_reg <= lc_reg ? S_WCOMMIT : S_EMIT;
                    end
                    else if (!i_reg[3])
                        i_reg <= i_reg + 4'd1;
                end
                S_WCOMMIT:
                begin
                    efill_reg[page_reg] <= efill_reg[page_reg] + EFW'(1);
                    dfill_reg[page_reg] <= dfill_reg[page_reg] + DFW'(pw_len_reg);
                    pw_act_reg <= 1'b0;
                    state_reg <= S_EMIT;
                end
                S_SCAN:
                    if (n_reg == '0)
                    begin
                        st_reg <= ST_MISSING; state_reg <= S_EMIT;
                    end
                    else
                    begin
                        n_reg <= n_dec; state_reg <= S_SCANCHK;
                    end
                S_SCANCHK:
                    if (n_reg < EFW'(ENTRY_SLOTS) && erd_reg.id == id_reg)
                    begin
                        rec_reg <= erd_reg; cnt_reg <= nb; sl_reg <= erd_reg.len;
                        if (nb == '0)
                            state_reg <= S_EMIT;
                        else
                            state_reg <= S_RBYTE;
                    end
                    else
                        state_reg <= S_SCAN;
                S_RBYTE: state_reg <= S_RBYTECHK;
                S_RBYTECHK:
                begin
                    rd_reg[8*bc_reg[2:0] +: 8] <=
                        ((DFW'(rec_reg.off) + DFW'(done_reg)) < DFW'(DATA_BYTES)) ?
                        drd_reg : 8'h00;
                    bc_reg <= bc_reg + 4'd1;
                    done_reg <= done_p1[7:0];
                    if (done_p1[7:0] == cnt_reg || bc_reg == 4'd7)
                    begin
                        last_reg <= (done_p1[7:0] == cnt_reg);
                        state_reg <= S_EMIT;
                    end
                    else
                        state_reg <= S_RBYTE;
                end
                S_ROOM:
                    // start the write, compact once, or report a full store
                    if (room)
                    begin
                        pw_act_reg <= 1'b1; pw_id_reg <= id_reg;
                        pw_len_reg <= ln_reg; pw_got_reg <= '0;
                        state_reg <= S_WBYTE;
                    end
                    else if (!compacted_reg)
                    begin
                        compacted_reg <= 1'b1; cid_reg <= '0;
                        efill_reg[dst] <= '0; dfill_reg[dst] <= '0;
                        n_reg <= efill_reg[src]; rec_reg.id <= BAD_ID;
                        state_reg <= S_CSCAN;
                    end
                    else
                    begin
                        st_reg <= ST_FULL; state_reg <= S_EMIT;
                    end
                S_CSCAN:
                    if (n_reg == '0)
                        state_reg <= S_CNEXT;
                    else
                    begin
                        n_reg <= n_dec; state_reg <= S_CSCANCHK;
                    end
                S_CSCANCHK:
                    if (n_reg < EFW'(ENTRY_SLOTS) && erd_reg.id == cid_reg)
                    begin
                        rec_reg <= erd_reg; done_reg <= '0;
                        state_reg <= (erd_reg.len == '0) ? S_CNEXT : S_CBYTE;
                    end
                    else
                        state_reg <= S_CSCAN;
                S_CBYTE: state_reg <= S_CBYTEWR;
                S_CBYTEWR:
                begin
                    done_reg <= done_p1[7:0];
                    state_reg <= (done_p1[7:0] == rec_reg.len) ? S_CNEXT : S_CBYTE;
                end
                S_CNEXT:
                begin
                    // close out one compaction id, then advance or switch pages
                    if (rec_reg.id != BAD_ID)
                    begin
                        efill_reg[dst] <= efill_reg[dst] + EFW'(1);
                        dfill_reg[dst] <= dfill_reg[dst] + DFW'(rec_reg.len);
                    end
                    rec_reg.id <= BAD_ID;
                    if (cid_reg != BAD_ID - 8'd1)
                    begin
                        cid_reg <= cid_reg + 8'd1; n_reg <= efill_reg[src];
                        state_reg <= S_CSCAN;
                    end
                    else
                    begin
                        page_reg <= dst;
                        efill_reg[src] <= '0; dfill_reg[src] <= '0;
                        state_reg <= S_ROOM;
                    end
                end
                S_EMIT:
                begin
                    state_reg <= (last_reg || mode_reg == MODE_WRITE) ? S_IDLE : S_RBYTE;
                    if (mode_reg == MODE_READ && !last_reg)
                    begin
                        bc_reg <= '0; rd_reg <= '0;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_EMIT);
    assign status = st_reg;
    assign stored_length = sl_reg;
    assign read_data = rd_reg;
    assign byte_count = bc_reg;
    assign last = last_reg;

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_valid_busy, clk, rst_n, out_valid, busy)
    `ASSERT_IMPL(a_cnt_range, clk, rst_n, out_valid, byte_count <= 4'd8)
    `ASSERT_IMPL(a_err_last, clk, rst_n, out_valid && status != ST_OK, last)
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
endmodule
